// File: rtl/bmprle_pkg.sv
// Shared types and constants for the BMP RLE8/RLE4 span decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package bmprle_pkg;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_COMMAND,
		PH_DELTA_X,
		PH_DELTA_Y,
		PH_ABSOLUTE,
		PH_PAD
	} phase_t;

	localparam logic [7:0] CMD_EOL   = 8'd0;
	localparam logic [7:0] CMD_EOB   = 8'd1;
	localparam logic [7:0] CMD_DELTA = 8'd2;

	localparam logic [1:0] REG_FOUR_BIT = 2'd0;
	localparam logic [1:0] REG_BOTTOM_UP = 2'd1;
	localparam logic [1:0] REG_HEIGHT   = 2'd2;
	localparam logic [1:0] REG_STRIDE   = 2'd3;

	localparam logic [12:0] HEIGHT_CAP = 13'd4096;
	localparam logic [12:0] STRIDE_CAP = 13'd4096;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] column;
		logic [7:0]  count;
		logic [7:0]  pattern;
		logic        four_bit;
		logic        eoi;
	} span_req_t;

endpackage
`default_nettype wire

// File: rtl/bitmap_rle_span_decoder_core.sv
// Top level of the BMP RLE8/RLE4 span decoder: configuration registers,
// address pipeline and output register. Depends on bmprle_pkg, bmprle_parse.
//
// The decoder takes one compressed byte per clock and never stalls on its
// own. A byte that produces a span reaches the output register through the
// pipeline registers in order: the span request is registered as it is
// accepted, the row stage flips the row and forms the 13x13-bit row times
// stride product, and the output stage adds the column offset into the output
// register. Input is held off only when the output is back-pressured and
// the pipeline is full.
`default_nettype none
module bitmap_rle_span_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // [11:0] span_row, [27:12] span_column,
	                                         // [51:28] byte_address, [59:52] pixel_count,
	                                         // [67:60] pixel_pattern, [71:68] zero
	output logic [1:0]       m_axis_tuser,   // [0] odd_start, [1] out_of_range
	output logic             m_axis_tlast,   // end_of_image
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	import bmprle_pkg::*;

	logic        four_bit_q;
	logic        bottom_up_q;
	logic [12:0] height_q;
	logic [12:0] stride_q;

	span_req_t   req;
	logic        req_valid;
	logic        take;

	span_req_t   span_s1;
	logic        v_s1;
	logic        v_s2;
	logic        v_o;
	logic        load_s1, load_s2, load_o;

	logic [12:0] h_eff;
	logic [12:0] st_eff;
	logic        oor_c;
	logic [12:0] stored_c;

	logic [25:0] prod_s2;
	logic [15:0] colb_s2;
	logic [12:0] stored_s2;
	logic        oor_s2;
	logic [15:0] column_s2;
	logic [7:0]  count_s2;
	logic [7:0]  pattern_s2;
	logic        odd_s2;
	logic        eoi_s2;

	logic [23:0] addr_c;

	logic [11:0] row_o;
	logic [15:0] column_o;
	logic [23:0] addr_o;
	logic [7:0]  count_o;
	logic [7:0]  pattern_o;
	logic        odd_o;
	logic        oor_o;
	logic        eoi_o;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q  <= 1'b0;
			bottom_up_q <= 1'b1;
			height_q    <= 13'd1;
			stride_q    <= 13'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOUR_BIT:  four_bit_q  <= cfg_data[0];
				REG_BOTTOM_UP: bottom_up_q <= cfg_data[0];
				REG_HEIGHT:    height_q    <= cfg_data;
				REG_STRIDE:    stride_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign load_o        = v_s2 && (!v_o || m_axis_tready);
	assign load_s2       = v_s1 && (!v_s2 || load_o);
	assign s_axis_tready = !v_s1 || load_s2;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign load_s1       = take && req_valid;

	bmprle_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.stream_byte   (s_axis_tdata),
		.four_bit_mode (four_bit_q),
		.req           (req),
		.req_valid     (req_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_o  <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= 1'b1;
			end else if (load_s2) begin
				v_s1 <= 1'b0;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (load_o) begin
				v_s2 <= 1'b0;
			end
			if (load_o) begin
				v_o <= 1'b1;
			end else if (m_axis_tready) begin
				v_o <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			span_s1 <= req;
		end
	end

	// flip the row and form the row base address
	assign h_eff    = (height_q > HEIGHT_CAP) ? HEIGHT_CAP : height_q;
	assign st_eff   = (stride_q > STRIDE_CAP) ? STRIDE_CAP : stride_q;
	assign oor_c    = span_s1.row >= {3'd0, h_eff};
	assign stored_c = bottom_up_q ? (h_eff - 13'd1 - span_s1.row[12:0]) : span_s1.row[12:0];

	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_s2    <= stored_c * st_eff;
			colb_s2    <= span_s1.four_bit ? {1'b0, span_s1.column[15:1]} : span_s1.column;
			stored_s2  <= stored_c;
			oor_s2     <= oor_c && !span_s1.eoi;
			column_s2  <= span_s1.column;
			count_s2   <= span_s1.count;
			pattern_s2 <= span_s1.pattern;
			odd_s2     <= span_s1.four_bit && span_s1.column[0];
			eoi_s2     <= span_s1.eoi;
		end
	end

	assign addr_c = prod_s2[23:0] + {8'd0, colb_s2};

	always_ff @(posedge clk) begin
		if (load_o) begin
			row_o     <= (oor_s2 || eoi_s2) ? 12'd0 : stored_s2[11:0];
			addr_o    <= (oor_s2 || eoi_s2) ? 24'd0 : addr_c;
			column_o  <= column_s2;
			count_o   <= count_s2;
			pattern_o <= pattern_s2;
			odd_o     <= odd_s2;
			oor_o     <= oor_s2;
			eoi_o     <= eoi_s2;
		end
	end

	assign m_axis_tvalid = v_o;
	assign m_axis_tdata  = {4'd0, pattern_o, count_o, addr_o, column_o, row_o};
	assign m_axis_tuser  = {oor_o, odd_o};
	assign m_axis_tlast  = eoi_o;

endmodule
`default_nettype wire

// File: rtl/bmprle_parse.sv
// Byte parser: phase machine, row/column tracking and span requests.
// Depends on bmprle_pkg.
`default_nettype none
module bmprle_parse (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire logic [7:0]            stream_byte,
	input  wire logic                  four_bit_mode,
	output bmprle_pkg::span_req_t      req,
	output logic                       req_valid
);
	import bmprle_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  run_count_q, run_count_d;
	logic [7:0]  abs_left_q, abs_left_d;
	logic        pad_q, pad_d;
	logic [7:0]  delta_col_q, delta_col_d;
	logic [15:0] row_q, row_d;
	logic [15:0] col_q, col_d;
	logic [7:0]  n;
	logic [16:0] col_sum;
	logic [16:0] dcol_sum;
	logic [16:0] row_inc;
	logic [16:0] drow_sum;

	assign col_sum  = {1'b0, col_q} + {9'd0, (phase_q == PH_ABSOLUTE) ? n : run_count_q};
	assign dcol_sum = {1'b0, col_q} + {9'd0, delta_col_q};
	assign row_inc  = {1'b0, row_q} + 17'd1;
	assign drow_sum = {1'b0, row_q} + {9'd0, stream_byte};

	always_comb begin
		n = (four_bit_mode && abs_left_q >= 8'd2) ? 8'd2 : 8'd1;
		if (n > abs_left_q) begin
			n = abs_left_q;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		run_count_d = run_count_q;
		abs_left_d  = abs_left_q;
		pad_d       = pad_q;
		delta_col_d = delta_col_q;
		row_d       = row_q;
		col_d       = col_q;
		req_valid   = 1'b0;
		req.row      = row_q;
		req.column   = col_q;
		req.count    = run_count_q;
		req.pattern  = stream_byte;
		req.four_bit = four_bit_mode;
		req.eoi      = 1'b0;
		case (phase_q)
			PH_COUNT: begin
				run_count_d = stream_byte;
				phase_d     = PH_COMMAND;
			end
			PH_COMMAND: begin
				phase_d = PH_COUNT;
				if (run_count_q != 8'd0) begin
					req_valid = 1'b1;
					col_d     = col_sum[16] ? 16'hFFFF : col_sum[15:0];
				end else if (stream_byte == CMD_EOL) begin
					row_d = row_inc[16] ? 16'hFFFF : row_inc[15:0];
					col_d = '0;
				end else if (stream_byte == CMD_EOB) begin
					req_valid    = 1'b1;
					req.row      = '0;
					req.column   = '0;
					req.count    = '0;
					req.pattern  = '0;
					req.four_bit = 1'b0;
					req.eoi      = 1'b1;
					row_d        = '0;
					col_d        = '0;
					run_count_d  = '0;
					abs_left_d   = '0;
					pad_d        = 1'b0;
					delta_col_d  = '0;
				end else if (stream_byte == CMD_DELTA) begin
					phase_d = PH_DELTA_X;
				end else begin
					abs_left_d = stream_byte;
					if (four_bit_mode) begin
						pad_d = (stream_byte[1:0] == 2'd1) || (stream_byte[1:0] == 2'd2);
					end else begin
						pad_d = stream_byte[0];
					end
					phase_d = PH_ABSOLUTE;
				end
			end
			PH_DELTA_X: begin
				delta_col_d = stream_byte;
				phase_d     = PH_DELTA_Y;
			end
			PH_DELTA_Y: begin
				col_d   = dcol_sum[16] ? 16'hFFFF : dcol_sum[15:0];
				row_d   = drow_sum[16] ? 16'hFFFF : drow_sum[15:0];
				phase_d = PH_COUNT;
			end
			PH_ABSOLUTE: begin
				req_valid  = 1'b1;
				req.count  = n;
				abs_left_d = abs_left_q - n;
				col_d      = col_sum[16] ? 16'hFFFF : col_sum[15:0];
				if (abs_left_q == n) begin
					phase_d = pad_q ? PH_PAD : PH_COUNT;
				end
			end
			PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = PH_COUNT;
			end
			default: begin
				phase_d = PH_COUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			run_count_q <= '0;
			abs_left_q  <= '0;
			pad_q       <= 1'b0;
			delta_col_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			run_count_q <= run_count_d;
			abs_left_q  <= abs_left_d;
			pad_q       <= pad_d;
			delta_col_q <= delta_col_d;
			row_q       <= row_d;
			col_q       <= col_d;
		end
	end

endmodule
`default_nettype wire

// File: dv/bitmap_rle_span_decoder_core_tb.sv
// Self-checking testbench for bitmap_rle_span_decoder_core: feeds RLE8/RLE4 byte streams and
// compares every span word against an in-bench decoder model with its own register copies.
// Depends on bmprle_pkg and the RTL of the block; needs no files or arguments.
`default_nettype none
module bitmap_rle_span_decoder_core_tb;
	import bmprle_pkg::*;

	typedef struct {
		logic [11:0] row;
		logic [15:0] column;
		logic [23:0] addr;
		logic [7:0]  count;
		logic [7:0]  pattern;
		logic        odd;
		logic        oor;
		logic        eoi;
	} span_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	logic        cfg_four_bit  = 1'b0;
	logic        cfg_bottom_up = 1'b1;
	logic [12:0] cfg_height    = 13'd1;
	logic [12:0] cfg_stride    = 13'd4;

	phase_t      parse_at  = PH_COUNT;
	logic [7:0]  run_len   = '0;
	logic [7:0]  abs_left  = '0;
	logic [7:0]  delta_x   = '0;
	logic        pad_due   = 1'b0;
	logic [15:0] cur_row   = '0;
	logic [15:0] cur_col   = '0;

	span_t       spans_due[$];
	span_t       want_span;
	int          fault_count   = 0;
	int          bytes_fed     = 0;
	bit          no_idle       = 1'b0;
	bit          sink_hold_req = 1'b0;

	bitmap_rle_span_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	function automatic void push_span(input logic [7:0] count, input logic [7:0] pattern);
		logic [12:0] h;
		logic [12:0] st;
		logic [15:0] col_bytes;
		logic [15:0] stored;
		logic [31:0] addr;
		span_t s;
		h = (cfg_height > HEIGHT_CAP) ? HEIGHT_CAP : cfg_height;
		st = (cfg_stride > STRIDE_CAP) ? STRIDE_CAP : cfg_stride;
		col_bytes = cfg_four_bit ? (cur_col >> 1) : cur_col;
		s = '{default: '0};
		s.oor = (cur_row >= {3'b0, h});
		if (!s.oor) begin
			stored = cfg_bottom_up ? ({3'b0, h} - 16'd1 - cur_row) : cur_row;
			addr = {16'b0, stored} * {19'b0, st} + {16'b0, col_bytes};
			s.row = stored[11:0];
			s.addr = addr[23:0];
		end
		s.column = cur_col;
		s.count = count;
		s.pattern = pattern;
		s.odd = cfg_four_bit & cur_col[0];
		spans_due.push_back(s);
		cur_col = sat16(cur_col, {8'b0, count});
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		logic [7:0] n;
		span_t s;
		case (parse_at)
			PH_COUNT: begin
				run_len = b;
				parse_at = PH_COMMAND;
			end
			PH_COMMAND: begin
				if (run_len != 0) begin
					parse_at = PH_COUNT;
					push_span(run_len, b);
				end else if (b == CMD_EOL) begin
					cur_row = sat16(cur_row, 16'd1);
					cur_col = '0;
					parse_at = PH_COUNT;
				end else if (b == CMD_EOB) begin
					s = '{default: '0};
					s.eoi = 1'b1;
					spans_due.push_back(s);
					cur_row = '0;
					cur_col = '0;
					parse_at = PH_COUNT;
					run_len = '0;
					abs_left = '0;
					pad_due = 1'b0;
					delta_x = '0;
				end else if (b == CMD_DELTA) begin
					parse_at = PH_DELTA_X;
				end else begin
					abs_left = b;
					pad_due = cfg_four_bit ? (b[1:0] == 2'd1 || b[1:0] == 2'd2) : b[0];
					parse_at = PH_ABSOLUTE;
				end
			end
			PH_DELTA_X: begin
				delta_x = b;
				parse_at = PH_DELTA_Y;
			end
			PH_DELTA_Y: begin
				cur_col = sat16(cur_col, {8'b0, delta_x});
				cur_row = sat16(cur_row, {8'b0, b});
				parse_at = PH_COUNT;
			end
			PH_ABSOLUTE: begin
				n = (cfg_four_bit && abs_left >= 8'd2) ? 8'd2 : 8'd1;
				if (n > abs_left)
					n = abs_left;
				abs_left = abs_left - n;
				if (abs_left == 0)
					parse_at = pad_due ? PH_PAD : PH_COUNT;
				push_span(n, b);
			end
			PH_PAD: begin
				pad_due = 1'b0;
				parse_at = PH_COUNT;
			end
			default: parse_at = PH_COUNT;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (spans_due.size() == 0) begin
				$error("span word with none due: tdata %0h tuser %0h tlast %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fault_count++;
			end else begin
				want_span = spans_due.pop_front();
				check_field("span_row", 24'(want_span.row), 24'(m_axis_tdata[11:0]));
				check_field("span_column", 24'(want_span.column), 24'(m_axis_tdata[27:12]));
				check_field("byte_address", want_span.addr, m_axis_tdata[51:28]);
				check_field("pixel_count", 24'(want_span.count), 24'(m_axis_tdata[59:52]));
				check_field("pixel_pattern", 24'(want_span.pattern), 24'(m_axis_tdata[67:60]));
				check_field("odd_start", 24'(want_span.odd), 24'(m_axis_tuser[0]));
				check_field("out_of_range", 24'(want_span.oor), 24'(m_axis_tuser[1]));
				check_field("end_of_image", 24'(want_span.eoi), 24'(m_axis_tlast));
			end
		end
	end

	initial begin : sink
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// Enter and leave at a falling edge; valid stays high between back-to-back words.
	task automatic put_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(b);
		bytes_fed++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (spans_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FOUR_BIT:  cfg_four_bit = val[0];
			REG_BOTTOM_UP: cfg_bottom_up = val[0];
			REG_HEIGHT:    cfg_height = val;
			REG_STRIDE:    cfg_stride = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic fb, input logic bu, input logic [12:0] h,
			input logic [12:0] st);
		drain();
		write_reg(REG_FOUR_BIT, {12'b0, fb});
		write_reg(REG_BOTTOM_UP, {12'b0, bu});
		write_reg(REG_HEIGHT, h);
		write_reg(REG_STRIDE, st);
		cfg_valid <= 1'b0;
	endtask

	task automatic realign();
		while (parse_at != PH_COUNT)
			put_byte(8'($urandom));
	endtask

	task automatic feed_random_command();
		int pick;
		logic [7:0] cnt;
		pick = $urandom_range(99);
		realign();
		if (pick < 38) begin
			cnt = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) :
				8'($urandom_range(16, 1));
			put_byte(cnt);
			put_byte(8'($urandom));
		end else if (pick < 56) begin
			cnt = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 3)) :
				8'($urandom_range(12, 3));
			put_byte(8'h00);
			put_byte(cnt);
			realign();
		end else if (pick < 66) begin
			put_byte(8'h00);
			put_byte(CMD_EOL);
		end else if (pick < 76) begin
			put_byte(8'h00);
			put_byte(CMD_DELTA);
			put_byte(($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(9)));
			put_byte(($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(2)));
		end else if (pick < 80) begin
			put_byte(8'h00);
			put_byte(CMD_EOB);
		end else begin
			repeat ($urandom_range(3, 1))
				put_byte(8'($urandom));
		end
	endtask

	task automatic test_rle8_directed();
		put_byte(8'h01); put_byte(8'h00);
		put_byte(8'hFF); put_byte(8'hFF);
		put_byte(8'h00); put_byte(CMD_EOL);
		put_byte(8'h03); put_byte(8'hAA);
		put_byte(8'h00); put_byte(CMD_DELTA); put_byte(8'h05); put_byte(8'h00);
		put_byte(8'h00); put_byte(8'h03);
		put_byte(8'h11); put_byte(8'h22); put_byte(8'h33); put_byte(8'h00);
		put_byte(8'h00); put_byte(CMD_EOB);
	endtask

	task automatic test_rle4_directed();
		set_config(1'b1, 1'b0, HEIGHT_CAP, STRIDE_CAP);
		put_byte(8'h05); put_byte(8'h5A);
		put_byte(8'h00); put_byte(8'h05);
		put_byte(8'h12); put_byte(8'h34); put_byte(8'h56); put_byte(8'h00);
		put_byte(8'h00); put_byte(CMD_EOL);
		put_byte(8'h03); put_byte(8'hC3);
		put_byte(8'h00); put_byte(CMD_EOB);
	endtask

	task automatic test_mode_switch_mid_run();
		set_config(1'b0, 1'b1, 13'd8, 13'd16);
		put_byte(8'h00); put_byte(8'h07);
		put_byte(8'h81); put_byte(8'h7E);
		set_config(1'b1, 1'b1, 13'd8, 13'd16);
		realign();
		put_byte(8'h00); put_byte(CMD_EOB);
	endtask

	// Land on the last row for an address wrap, then step past the height.
	task automatic test_position_limits();
		set_config(1'b0, 1'b0, HEIGHT_CAP, STRIDE_CAP);
		no_idle = 1'b1;
		repeat (16) begin
			put_byte(8'h00); put_byte(CMD_DELTA); put_byte(8'hFF); put_byte(8'hFF);
		end
		put_byte(8'h00); put_byte(CMD_DELTA); put_byte(8'hFF); put_byte(8'h0F);
		put_byte(8'h02); put_byte(8'h99);
		put_byte(8'h00); put_byte(CMD_DELTA); put_byte(8'h00); put_byte(8'h01);
		put_byte(8'h04); put_byte(8'h3C);
		put_byte(8'h00); put_byte(CMD_EOL);
		put_byte(8'h02); put_byte(8'hE1);
		put_byte(8'h00); put_byte(CMD_EOB);
		no_idle = 1'b0;
	endtask

	task automatic test_output_hold();
		set_config(1'b0, 1'b1, 13'd64, 13'd256);
		sink_hold_req = 1'b1;
		repeat (80) begin
			put_byte(8'($urandom_range(255, 1)));
			put_byte(8'($urandom));
		end
		put_byte(8'h00); put_byte(CMD_EOB);
	endtask

	task automatic test_random_streams();
		int start;
		for (int k = 0; k < 8; k++) begin
			case (k)
				0: set_config(1'b0, 1'b1, 13'd16, 13'd64);
				1: set_config(1'b1, 1'b0, 13'd24, 13'd8);
				2: set_config(1'b1, 1'b1, HEIGHT_CAP, STRIDE_CAP);
				3: set_config(1'b0, 1'b0, 13'd1, 13'd4);
				4: set_config(1'b0, 1'b1, 13'd0, 13'd12);
				5: set_config(1'b1, 1'b1, 13'h1FFF, 13'h1FFF);
				6: set_config(1'b0, 1'b0, 13'd40, 13'd7);
				default: set_config(1'b1, 1'b0, 13'd33, 13'd4092);
			endcase
			start = bytes_fed;
			while (bytes_fed - start < 45)
				feed_random_command();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_rle8_directed();
		test_rle4_directed();
		test_mode_switch_mid_run();
		test_position_limits();
		test_output_hold();
		test_random_streams();
		drain();
		repeat (16) @(negedge clk);
		if (fault_count == 0 && spans_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// File: bitmap_rle_span_decoder_core.f
rtl/bmprle_pkg.sv
rtl/bmprle_parse.sv
rtl/bitmap_rle_span_decoder_core.sv
dv/bitmap_rle_span_decoder_core_tb.sv
